### rtl/gsv_pkg.sv
// Shared types and constants for the grapheme segment validator.
package gsv_pkg;

  localparam int CODE_W = 21;
  localparam int LEN_W  = 8;
  localparam int LEN_MAX = 255;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_WHITE = 2'd1,
    CLS_COMB  = 2'd2,
    CLS_LINK  = 2'd3
  } class_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TWO_LINKS = 3'd1,
    ST_BAD_INDIC = 3'd2,
    ST_BAD_THAI  = 3'd3,
    ST_DISCARD   = 3'd4
  } status_t;

  localparam code_t CODE_SPACE = 21'h00020;
  localparam code_t CODE_ZWNJ  = 21'h0200C;
  localparam code_t CODE_ZWJ   = 21'h0200D;

  typedef struct packed {
    logic bad_indic;
    logic bad_thai;
  } pair_flags_t;

endpackage

### rtl/gsv_if.sv
// Valid/ready channel interfaces for the input and result items.
interface gsv_in_if;
  import gsv_pkg::*;
  logic        valid;
  logic        ready;
  code_t       code_point;
  logic [1:0]  char_class;
  logic        last_in_text;

  modport source (output valid, output code_point, output char_class,
                  output last_in_text, input ready);
  modport sink   (input valid, input code_point, input char_class,
                  input last_in_text, output ready);
endinterface

interface gsv_out_if;
  import gsv_pkg::*;
  logic        valid;
  logic        ready;
  code_t       code_out;
  logic        starts_grapheme;
  len_t        closed_length;
  len_t        final_length;
  logic [2:0]  status;

  modport source (output valid, output code_out, output starts_grapheme,
                  output closed_length, output final_length, output status,
                  input ready);
  modport sink   (input valid, input code_out, input starts_grapheme,
                  input closed_length, input final_length, input status,
                  output ready);
endinterface

### rtl/gsv_pair_check.sv
// Indic vowel and Thai pair rules for one adjacent pair of codes.
module gsv_pair_check (
  input  gsv_pkg::code_t       prev_code,
  input  gsv_pkg::code_t       code,
  output gsv_pkg::pair_flags_t flags
);
  import gsv_pkg::*;

  function automatic logic in_rng(code_t c, code_t lo, code_t hi);
    return (c >= lo) && (c <= hi);
  endfunction

  logic p_cons, p_tonable, p_tone, p_pre;
  logic c_tonable, c_tone, c_pre;
  logic indic;
  logic [6:0] thai_rule;

  always_comb begin
    indic =
      (prev_code == 21'h905 && (code == 21'h946 || code == 21'h93E)) ||
      (prev_code == 21'h909 && code == 21'h941) ||
      (prev_code == 21'h90F && in_rng(code, 21'h945, 21'h947)) ||
      (prev_code == 21'h905 && in_rng(code, 21'h949, 21'h94C)) ||
      (prev_code == 21'h906 && in_rng(code, 21'h949, 21'h94C)) ||
      (prev_code == 21'h93E && in_rng(code, 21'h945, 21'h948)) ||
      (prev_code == 21'h94D && in_rng(code, 21'h93E, 21'h94C)) ||
      (prev_code == 21'h985 && code == 21'h9BE) ||
      (prev_code == 21'hC12 && (code == 21'hC55 || code == 21'hC4C)) ||
      (prev_code == 21'hC92 && code == 21'hCCC);

    p_cons    = in_rng(prev_code, 21'hE01, 21'hE2E);
    p_tonable = in_rng(prev_code, 21'hE34, 21'hE39) || prev_code == 21'hE31;
    p_tone    = in_rng(prev_code, 21'hE48, 21'hE4B);
    p_pre     = in_rng(prev_code, 21'hE40, 21'hE44);
    c_tonable = in_rng(code, 21'hE34, 21'hE39) || code == 21'hE31;
    c_tone    = in_rng(code, 21'hE48, 21'hE4B);
    c_pre     = in_rng(code, 21'hE40, 21'hE44);

    thai_rule[0] = c_tone && !(p_cons || p_tonable);
    thai_rule[1] = (c_tonable || code == 21'hE47) && !p_cons;
    thai_rule[2] = code == 21'hE4C &&
                   !(p_cons || prev_code == 21'hE38 || prev_code == 21'hE34);
    thai_rule[3] = code == 21'hE4D &&
                   !(p_cons || prev_code == 21'hE48 || prev_code == 21'hE49);
    // sara a after sara aa, and sara aa after nikhahit, are allowed
    thai_rule[4] = (code == 21'hE30 || code == 21'hE32 || code == 21'hE33) &&
                   !(p_cons || p_tone) &&
                   !(prev_code == 21'hE32 && code == 21'hE30) &&
                   !(prev_code == 21'hE4D && code == 21'hE32);
    thai_rule[5] = c_pre && (p_pre || prev_code == 21'hE31 || prev_code == 21'hE37);
    thai_rule[6] = in_rng(code, 21'hE30, 21'hE4D) && prev_code == 21'hE24;

    flags.bad_indic = indic;
    flags.bad_thai  = |thai_rule;
  end

endmodule

### rtl/grapheme_segment_validator_core.sv
// The input item is taken into the input register; its result then moves on to the result
// register once that register is free or being read. Throughput: one item per cycle while
// results are taken; all checks are combinational logic on the input register. While a
// result waits, one more item is taken into the input register, then the input stalls.
// Synchronous active-high reset clears valids and returns the grapheme state to
// space/whitespace, count zero, no error latched.
module grapheme_segment_validator_core #(
  parameter int MAX_GRAPHEME_LEN = 255
) (
  input logic        clk,
  input logic        rst,
  gsv_in_if.sink     in_ch,
  gsv_out_if.source  out_ch
);
  import gsv_pkg::*;

  localparam int CNT_W  = $clog2(MAX_GRAPHEME_LEN + 1);
  localparam int WIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_GRAPHEME_LEN);

  // input register
  logic   s1_valid;
  code_t  s1_code;
  class_t s1_class;
  logic   s1_last;

  // grapheme state
  code_t            before_previous_code;
  code_t            previous_code;
  class_t           previous_class;
  logic [CNT_W-1:0] grapheme_count;
  logic             error_latched;

  // result register
  logic    out_valid;
  code_t   out_code;
  logic    out_starts;
  len_t    out_closed;
  len_t    out_final;
  status_t out_status;

  logic advance, s1_fire;
  pair_flags_t flags;
  status_t status_next;
  logic comb, fwd, brk, starts_next;
  logic [CNT_W-1:0] count_base, count_next;
  len_t closed_next, final_next;

  function automatic len_t clamp_len(logic [CNT_W-1:0] n);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(n);
    return (w > WIDE_W'(LEN_MAX)) ? len_t'(LEN_MAX) : w[LEN_W-1:0];
  endfunction

  gsv_pair_check u_pair (
    .prev_code (previous_code),
    .code      (s1_code),
    .flags     (flags)
  );

  assign advance     = !out_valid || out_ch.ready;
  assign s1_fire     = s1_valid && advance;
  assign in_ch.ready = !s1_valid || advance;

  always_comb begin
    logic pair_zone;
    pair_zone = previous_class != CLS_WHITE && s1_class != CLS_WHITE;
    priority if (error_latched) begin
      status_next = ST_DISCARD;
    end else if (previous_class == CLS_LINK && s1_class == CLS_LINK) begin
      status_next = ST_TWO_LINKS;
    end else if (pair_zone && flags.bad_indic) begin
      status_next = ST_BAD_INDIC;
    end else if (pair_zone && flags.bad_thai) begin
      status_next = ST_BAD_THAI;
    end else begin
      status_next = ST_OK;
    end

    comb = s1_class == CLS_COMB || s1_class == CLS_LINK;
    fwd  = previous_code == CODE_ZWJ || previous_class == CLS_LINK ||
           (previous_code == CODE_ZWNJ &&
            (s1_class == CLS_LINK || before_previous_code == CODE_ZWJ));
    brk         = grapheme_count != '0 && !comb && !fwd;
    starts_next = status_next == ST_OK && (grapheme_count == '0 || (!comb && !fwd));
    count_base  = brk ? '0 : grapheme_count;
    count_next  = (count_base < CNT_MAX) ? count_base + 1'b1 : count_base;
    closed_next = (status_next == ST_OK && brk) ? clamp_len(grapheme_count) : '0;
    final_next  = (status_next == ST_OK && s1_last) ? clamp_len(count_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid             <= 1'b0;
      out_valid            <= 1'b0;
      before_previous_code <= CODE_SPACE;
      previous_code        <= CODE_SPACE;
      previous_class       <= CLS_WHITE;
      grapheme_count       <= '0;
      error_latched        <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid <= in_ch.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (s1_fire) begin
        if (s1_last) begin
          // end of text: back to the reset state, error latch included
          before_previous_code <= CODE_SPACE;
          previous_code        <= CODE_SPACE;
          previous_class       <= CLS_WHITE;
          grapheme_count       <= '0;
          error_latched        <= 1'b0;
        end else if (status_next == ST_OK) begin
          before_previous_code <= brk ? CODE_SPACE : previous_code;
          previous_code        <= s1_code;
          previous_class       <= s1_class;
          grapheme_count       <= count_next;
        end else if (status_next != ST_DISCARD) begin
          error_latched <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_code  <= in_ch.code_point;
      s1_class <= class_t'(in_ch.char_class);
      s1_last  <= in_ch.last_in_text;
    end
    if (s1_fire) begin
      out_code   <= s1_code;
      out_starts <= starts_next;
      out_closed <= closed_next;
      out_final  <= final_next;
      out_status <= status_next;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.code_out        = out_code;
  assign out_ch.starts_grapheme = out_starts;
  assign out_ch.closed_length   = out_closed;
  assign out_ch.final_length    = out_final;
  assign out_ch.status          = out_status;

  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |->
      !out_starts && out_closed == '0 && out_final == '0)
    else $error("error or discard result carries grapheme data");

  a_closed_starts: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_closed != '0 |-> out_starts)
    else $error("grapheme closed without a new one starting");

  a_text_end_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> !error_latched && grapheme_count == '0)
    else $error("state not cleared after end of text");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    grapheme_count <= CNT_MAX)
    else $error("grapheme count above its limit");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ch.ready)
    else $error("input stalled with empty result register");

endmodule

### verif/grapheme_segment_validator_core_tb.sv
// Self-checking testbench for the grapheme segment validator core.
module grapheme_segment_validator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsv_pkg::*;

  localparam int MAX_SEG      = 255;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    code_t   code;
    logic    starts;
    len_t    closed;
    len_t    fin;
    status_t status;
  } seg_result_t;

  logic clk = 1'b0;
  logic rst;

  gsv_in_if  in_ch();
  gsv_out_if out_ch();

  grapheme_segment_validator_core #(.MAX_GRAPHEME_LEN(MAX_SEG)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Segmenter state as the block should hold it
  code_t  last_cp;
  code_t  last2_cp;
  class_t last_cls;
  int     run_len;
  bit     text_failed;

  seg_result_t pending_results[$];
  int  n_fail;
  int  n_sent;
  int  cycle_cnt;
  bit  idle_on;
  bit  hold_go;
  bit  sink_hold;

  task automatic flag_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got 0x%0h want 0x%0h (item %0d)", what, got, want, n_sent);
    n_fail++;
  endtask

  function automatic bit in_span(code_t v, code_t lo, code_t hi);
    return v >= lo && v <= hi;
  endfunction

  function automatic bit indic_pair_bad(code_t p, code_t c);
    return (p == 'h905 && (c == 'h946 || c == 'h93E)) ||
           (p == 'h909 && c == 'h941) ||
           (p == 'h90F && in_span(c, 'h945, 'h947)) ||
           ((p == 'h905 || p == 'h906) && in_span(c, 'h949, 'h94C)) ||
           (p == 'h93E && in_span(c, 'h945, 'h948)) ||
           (p == 'h94D && in_span(c, 'h93E, 'h94C)) ||
           (p == 'h985 && c == 'h9BE) ||
           (p == 'hC12 && (c == 'hC55 || c == 'hC4C)) ||
           (p == 'hC92 && c == 'hCCC);
  endfunction

  function automatic bit thai_pair_bad(code_t p, code_t c);
    bit p_cons, p_tone, p_tonable, c_tone, c_tonable, p_pre;
    p_cons    = in_span(p, 'hE01, 'hE2E);
    p_tone    = in_span(p, 'hE48, 'hE4B);
    p_tonable = in_span(p, 'hE34, 'hE39) || p == 'hE31;
    p_pre     = in_span(p, 'hE40, 'hE44);
    c_tone    = in_span(c, 'hE48, 'hE4B);
    c_tonable = in_span(c, 'hE34, 'hE39) || c == 'hE31;
    if (c_tone && !(p_cons || p_tonable)) return 1'b1;
    if ((c_tonable || c == 'hE47) && !p_cons) return 1'b1;
    if (c == 'hE4C && !(p_cons || p == 'hE38 || p == 'hE34)) return 1'b1;
    if (c == 'hE4D && !(p_cons || p == 'hE48 || p == 'hE49)) return 1'b1;
    if ((c == 'hE30 || c == 'hE32 || c == 'hE33) && !(p_cons || p_tone) &&
        !(p == 'hE32 && c == 'hE30) && !(p == 'hE4D && c == 'hE32)) return 1'b1;
    if (in_span(c, 'hE40, 'hE44) && (p_pre || p == 'hE31 || p == 'hE37)) return 1'b1;
    if (in_span(c, 'hE30, 'hE4D) && p == 'hE24) return 1'b1;
    return 1'b0;
  endfunction

  function automatic len_t clamp_len(int n);
    return len_t'(n > LEN_MAX ? LEN_MAX : n);
  endfunction

  task automatic clear_segmenter();
    last_cp     = CODE_SPACE;
    last2_cp    = CODE_SPACE;
    last_cls    = CLS_WHITE;
    run_len     = 0;
    text_failed = 1'b0;
  endtask

  // Advance the segmenter by one accepted code and queue its result
  task automatic segment_code(code_t cp, class_t cc, bit last);
    seg_result_t r;
    bit joins, fwd;
    r = '0;
    r.code = cp;
    r.status = ST_OK;
    if (text_failed) begin
      r.status = ST_DISCARD;
    end else if (last_cls == CLS_LINK && cc == CLS_LINK) begin
      r.status = ST_TWO_LINKS;
    end else if (last_cls != CLS_WHITE && cc != CLS_WHITE && indic_pair_bad(last_cp, cp)) begin
      r.status = ST_BAD_INDIC;
    end else if (last_cls != CLS_WHITE && cc != CLS_WHITE && thai_pair_bad(last_cp, cp)) begin
      r.status = ST_BAD_THAI;
    end else begin
      joins = cc == CLS_COMB || cc == CLS_LINK;
      fwd = last_cp == CODE_ZWJ || last_cls == CLS_LINK ||
            (last_cp == CODE_ZWNJ && (cc == CLS_LINK || last2_cp == CODE_ZWJ));
      if (run_len == 0) begin
        r.starts = 1'b1;
      end else if (!joins && !fwd) begin
        r.starts = 1'b1;
        r.closed = clamp_len(run_len);
        run_len = 0;
        last_cp = CODE_SPACE;
      end
      if (run_len < MAX_SEG) run_len++;
      last2_cp = last_cp;
      last_cp  = cp;
      last_cls = cc;
      if (last) r.fin = clamp_len(run_len);
    end
    if (r.status != ST_OK && r.status != ST_DISCARD) text_failed = 1'b1;
    if (last) clear_segmenter();
    pending_results.push_back(r);
  endtask

  // Offer one item from the falling edge; return at the edge that accepts it
  task automatic send_code(code_t cp, class_t cc, bit last);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.code_point   = cp;
    in_ch.char_class   = cc;
    in_ch.last_in_text = last;
    do @(posedge clk); while (!in_ch.ready);
    segment_code(cp, cc, last);
    n_sent++;
  endtask

  function automatic code_t pick_code();
    case ($urandom_range(0, 11))
      0, 1: return code_t'($urandom_range(0, 'h10FFFF));
      2:    return code_t'($urandom_range('h905, 'h90F));
      3:    return code_t'($urandom_range('h93E, 'h94D));
      4: begin
        case ($urandom_range(0, 5))
          0:       return 'h985;
          1:       return 'h9BE;
          2:       return 'hC12;
          3:       return $urandom_range(0, 1) ? code_t'('hC55) : code_t'('hC4C);
          4:       return 'hC92;
          default: return 'hCCC;
        endcase
      end
      5, 6: begin
        if ($urandom_range(0, 3) == 0) return 'hE24;
        return code_t'($urandom_range('hE00, 'hE4F));
      end
      7:       return $urandom_range(0, 1) ? CODE_ZWJ : CODE_ZWNJ;
      8:       return CODE_SPACE;
      default: return code_t'($urandom_range('h41, 'h7A));
    endcase
  endfunction

  function automatic class_t pick_class(code_t cp);
    int roll;
    roll = $urandom_range(0, 9);
    if (cp == CODE_SPACE && roll < 8) return CLS_WHITE;
    if (roll < 4) return CLS_OTHER;
    if (roll == 4) return CLS_WHITE;
    if (roll < 9) return CLS_COMB;
    return CLS_LINK;
  endfunction

  // Well-formed texts with random content, and some noise with random text ends
  task automatic send_random_texts(int n_items);
    int stop_at, len;
    code_t cp;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 12))
          send_code(code_t'($urandom_range(0, 'h10FFFF)), class_t'($urandom_range(0, 3)),
                    $urandom_range(0, 9) == 0);
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          cp = pick_code();
          send_code(cp, pick_class(cp), i == len - 1);
        end
      end
    end
  endtask

  task automatic test_basic_segments();
    send_code('h41, CLS_OTHER, 1'b1);
    send_code('h000000, CLS_OTHER, 1'b0);
    send_code('h10FFFF, CLS_COMB, 1'b0);
    send_code(CODE_SPACE, CLS_WHITE, 1'b0);
    send_code('h62, CLS_OTHER, 1'b1);
  endtask

  task automatic test_joiners();
    send_code('h915, CLS_OTHER, 1'b0);
    send_code('h94D, CLS_LINK, 1'b0);
    send_code('h937, CLS_OTHER, 1'b0);
    send_code(CODE_ZWJ, CLS_OTHER, 1'b0);
    send_code('h61, CLS_OTHER, 1'b0);
    send_code(CODE_ZWNJ, CLS_OTHER, 1'b0);
    send_code('h94D, CLS_LINK, 1'b0);
    send_code('h62, CLS_OTHER, 1'b0);
    send_code(CODE_ZWJ, CLS_COMB, 1'b0);
    send_code(CODE_ZWNJ, CLS_OTHER, 1'b0);
    send_code('h63, CLS_OTHER, 1'b1);
  endtask

  task automatic test_pair_errors();
    send_code('h915, CLS_OTHER, 1'b0);
    send_code('h94D, CLS_LINK, 1'b0);
    send_code('h94D, CLS_LINK, 1'b0);
    send_code('h41, CLS_OTHER, 1'b0);
    send_code('h42, CLS_OTHER, 1'b1);
    send_code('h905, CLS_OTHER, 1'b0);
    send_code('h946, CLS_COMB, 1'b0);
    send_code(CODE_SPACE, CLS_WHITE, 1'b1);
    send_code('hE01, CLS_OTHER, 1'b0);
    send_code('hE48, CLS_COMB, 1'b0);
    send_code('hE40, CLS_OTHER, 1'b0);
    send_code('hE40, CLS_OTHER, 1'b0);
    send_code('hE24, CLS_OTHER, 1'b1);
    send_code('hE24, CLS_OTHER, 1'b0);
    send_code('hE30, CLS_COMB, 1'b1);
  endtask

  // Grapheme just past the counter limit: the final length, then the closing length saturate
  task automatic test_long_grapheme();
    send_code('h61, CLS_OTHER, 1'b0);
    for (int i = 0; i < 255; i++)
      send_code(code_t'($urandom_range('h300, 'h36F)), CLS_COMB, i == 254);
    send_code('h61, CLS_OTHER, 1'b0);
    for (int i = 0; i < 255; i++)
      send_code(code_t'($urandom_range('h300, 'h36F)), CLS_COMB, 1'b0);
    send_code('h62, CLS_OTHER, 1'b1);
  endtask

  // Hold the result side off while items keep coming, so the input stalls
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_go = 1'b1;
    send_random_texts(40);
    idle_on = 1'b1;
  endtask

  task automatic test_random();
    int stop_at;
    stop_at = n_sent + 40;
    while (n_sent < stop_at) begin
      idle_on = $urandom_range(0, 3) != 0;
      send_random_texts(20);
    end
    idle_on = 1'b0;
    send_random_texts(20);
  endtask

  always @(posedge clk) begin : check_result
    seg_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending, code", out_ch.code_out, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.code_out !== want.code)
          flag_mismatch("code_out", out_ch.code_out, want.code);
        if (out_ch.starts_grapheme !== want.starts)
          flag_mismatch("starts_grapheme", out_ch.starts_grapheme, want.starts);
        if (out_ch.closed_length !== want.closed)
          flag_mismatch("closed_length", out_ch.closed_length, want.closed);
        if (out_ch.final_length !== want.fin)
          flag_mismatch("final_length", out_ch.final_length, want.fin);
        if (out_ch.status !== want.status)
          flag_mismatch("status", out_ch.status, want.status);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               pending_results.size());
      $display("grapheme_segment_validator_core_tb NOT OK");
      $finish;
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        out_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b0;
        stall_left = $urandom_range(1, 15) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  initial begin : hold_off
    sink_hold = 1'b0;
    wait (hold_go);
    @(negedge clk);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    sink_hold = 1'b0;
  end

  initial begin
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.code_point   = '0;
    in_ch.char_class   = CLS_OTHER;
    in_ch.last_in_text = 1'b0;
    n_fail    = 0;
    n_sent    = 0;
    cycle_cnt = 0;
    idle_on   = 1'b1;
    hold_go   = 1'b0;
    clear_segmenter();
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_basic_segments();
    test_joiners();
    test_pair_errors();
    test_long_grapheme();
    test_backpressure();
    test_random();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("grapheme_segment_validator_core_tb OK");
    end else begin
      $display("grapheme_segment_validator_core_tb NOT OK");
    end
    $finish;
  end

endmodule
